FILE: hdl/dshot600_four_channel_transmitter_unit_macros.svh
// ----------------------------------------------------------------------------
// DShot600 transmitter assertion macros
// Shared assertion forms for the checker file of the transmitter.
// ----------------------------------------------------------------------------
`ifndef DSHOT600_FOUR_CHANNEL_TRANSMITTER_UNIT_MACROS_SVH
`define DSHOT600_FOUR_CHANNEL_TRANSMITTER_UNIT_MACROS_SVH

// Check on every rising edge outside reset.
`define DSH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define DSH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/dsh_pkg.sv
// ----------------------------------------------------------------------------
// DShot600 transmitter package
// Shared constants, codes, the queued operation type and the packet builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dsh_pkg;

  localparam int MOTORS      = 4;
  localparam int RESET_SLOTS = 30;

  localparam int STORE_N   = 4;
  localparam int VAL_W     = 11;
  localparam int REQ_W     = 16;
  localparam int CMD_W     = 6;
  localparam int REP_W     = 8;
  localparam int WORD_W    = 16;
  localparam int PIN_W     = 4;
  localparam int RCNT_W    = 6;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_LIMIT = 6'd47;
  localparam logic [VAL_W-1:0] CEIL_RST  = 11'd2047;
  localparam logic [VAL_W-1:0] FLOOR_RST = 11'd48;

  // Action codes of the request channel.
  localparam logic [2:0] ACT_SET   = 3'd0;
  localparam logic [2:0] ACT_FRAME = 3'd1;
  localparam logic [2:0] ACT_CMD   = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_CEIL  = 1'b0;
  localparam logic CFG_FLOOR = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MOTOR = 2'd1,
    ST_BAD_CMD   = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_SET,
    OP_FRAME,
    OP_CMD,
    OP_TICK,
    OP_STOP,
    OP_NOP,
    OP_BAD_MOTOR,
    OP_BAD_CMD
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [1:0]        motor;
    logic [VAL_W-1:0]  value;
    logic              tele;
    logic [WORD_W-1:0] cmd_word;
    logic [REP_W-1:0]  repeats;
  } op_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } q_ctrl_t;

  // Packet: value and telemetry bit, then XOR of the three upper nibbles.
  function automatic logic [WORD_W-1:0] make_packet(input logic [VAL_W-1:0] value,
                                                   input logic tele);
    logic [11:0] p;
    logic [3:0]  sum;
    p   = {value, tele};
    sum = p[3:0] ^ p[7:4] ^ p[11:8];
    return {p, sum};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/dsh_stream_if.sv
// ----------------------------------------------------------------------------
// DShot600 transmitter channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsh_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [2:0] motor_number;
  logic [15:0] throttle_request;
  logic       telemetry_request;
  logic [5:0] command_code;
  logic [7:0] repeat_count;

  modport source (output valid, action, motor_number, throttle_request,
                  telemetry_request, command_code, repeat_count, input ready);
  modport sink   (input valid, action, motor_number, throttle_request,
                  telemetry_request, command_code, repeat_count, output ready);
endinterface

interface dsh_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pin_levels;
  logic       frame_end;
  logic       sending;
  logic [1:0] status;

  modport source (output valid, pin_levels, frame_end, sending, status, input ready);
  modport sink   (input valid, pin_levels, frame_end, sending, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/dsh_queue.sv
// ----------------------------------------------------------------------------
// DShot600 operation queue
// Short register queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`default_nettype none

module dsh_queue
  import dsh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  op_in,
  input  wire logic pop,
  output q_ctrl_t   ctrl,
  output op_t       op_out
);

  op_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              full, empty;

  assign full   = (cnt_r == QCNT_W'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign op_out = mem_r[rptr_r];

  always_comb begin
    ctrl.push  = push;
    ctrl.pop   = pop;
    ctrl.full  = full;
    ctrl.empty = empty;
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= op_in;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dsh_front.sv
// ----------------------------------------------------------------------------
// DShot600 request front end
// Hold the limit registers, accept requests, clamp and classify them.
// ----------------------------------------------------------------------------
`default_nettype none

module dsh_front
  import dsh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [VAL_W-1:0] cfg_data,
  dsh_in_if.sink                in_ch,
  input  wire logic             q_full,
  output logic                  push,
  output op_t                   op
);

  logic [VAL_W-1:0] ceil_r, ceil_nxt;
  logic [VAL_W-1:0] floor_r, floor_nxt;
  logic [REQ_W-1:0] req_hi, req_clamp;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    ceil_nxt  = ceil_r;
    floor_nxt = floor_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CEIL:  ceil_nxt  = cfg_data;
        CFG_FLOOR: floor_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r  <= CEIL_RST;
      floor_r <= FLOOR_RST;
    end else begin
      ceil_r  <= ceil_nxt;
      floor_r <= floor_nxt;
    end
  end

  // Ceiling first, then raise nonzero values to the floor.
  always_comb begin
    req_hi = (in_ch.throttle_request > REQ_W'(ceil_r)) ? REQ_W'(ceil_r)
                                                       : in_ch.throttle_request;
    req_clamp = (req_hi != '0 && req_hi < REQ_W'(floor_r)) ? REQ_W'(floor_r) : req_hi;
  end

  always_comb begin
    op.kind     = OP_NOP;
    op.motor    = in_ch.motor_number[1:0];
    op.value    = req_clamp[VAL_W-1:0];
    op.tele     = in_ch.telemetry_request;
    op.cmd_word = make_packet(VAL_W'(in_ch.command_code), in_ch.telemetry_request);
    op.repeats  = (in_ch.repeat_count == '0) ? REP_W'(1) : in_ch.repeat_count;
    case (in_ch.action)
      ACT_SET: begin
        op.kind = (in_ch.motor_number >= 3'(MOTORS)) ? OP_BAD_MOTOR : OP_SET;
      end
      ACT_FRAME: op.kind = OP_FRAME;
      ACT_CMD: begin
        op.kind = (in_ch.command_code > CMD_LIMIT) ? OP_BAD_CMD : OP_CMD;
      end
      ACT_TICK: op.kind = OP_TICK;
      ACT_STOP: op.kind = OP_STOP;
      default:  op.kind = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/dsh_back.sv
// ----------------------------------------------------------------------------
// DShot600 execution back end
// Apply queued operations to the stores and slot counters, drive results.
// ----------------------------------------------------------------------------
`default_nettype none

module dsh_back
  import dsh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire op_t  op,
  output logic      pop,
  dsh_out_if.source out_ch
);

  logic [VAL_W-1:0]  thr_r  [STORE_N];
  logic [VAL_W-1:0]  thr_nxt [STORE_N];
  logic              tel_r  [STORE_N];
  logic              tel_nxt [STORE_N];
  logic [WORD_W-1:0] word_r [STORE_N];
  logic [WORD_W-1:0] word_nxt [STORE_N];
  logic [4:0]        bit_r, bit_nxt;      // bit 4 set: reset slots
  logic [2:0]        sub_r, sub_nxt;
  logic [RCNT_W-1:0] rcnt_r, rcnt_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt, rep_dec;
  logic              busy_r, busy_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [PIN_W-1:0]  pins_r, pins_nxt;
  logic              fend_r, fend_nxt;
  logic              send_r;
  status_t           stat_r, stat_nxt;

  assign pop = !q_empty && (!out_valid_r || out_ch.ready);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pin_levels = pins_r;
  assign out_ch.frame_end  = fend_r;
  assign out_ch.sending    = send_r;
  assign out_ch.status     = stat_r;

  always_comb begin
    thr_nxt  = thr_r;
    tel_nxt  = tel_r;
    word_nxt = word_r;
    bit_nxt  = bit_r;
    sub_nxt  = sub_r;
    rcnt_nxt = rcnt_r;
    rep_nxt  = rep_r;
    busy_nxt = busy_r;
    pins_nxt = '0;
    fend_nxt = 1'b0;
    stat_nxt = ST_OK;
    rep_dec  = (rep_r != '0) ? rep_r - 1'b1 : rep_r;
    if (pop) begin
      if (busy_r && op.kind != OP_TICK && op.kind != OP_NOP) begin
        stat_nxt = ST_BUSY;
      end else begin
        case (op.kind)
          OP_SET: begin
            thr_nxt[op.motor] = op.value;
            tel_nxt[op.motor] = op.tele;
          end
          OP_BAD_MOTOR: stat_nxt = ST_BAD_MOTOR;
          OP_BAD_CMD:   stat_nxt = ST_BAD_CMD;
          OP_FRAME, OP_CMD, OP_STOP: begin
            for (int m = 0; m < STORE_N; m++) begin
              case (op.kind)
                OP_FRAME: word_nxt[m] = make_packet(thr_r[m], tel_r[m]);
                OP_CMD:   word_nxt[m] = op.cmd_word;
                default: begin
                  thr_nxt[m]  = '0;
                  tel_nxt[m]  = 1'b0;
                  word_nxt[m] = make_packet('0, 1'b0);
                end
              endcase
            end
            bit_nxt  = '0;
            sub_nxt  = '0;
            rcnt_nxt = '0;
            rep_nxt  = (op.kind == OP_CMD) ? op.repeats : REP_W'(1);
            busy_nxt = 1'b1;
          end
          OP_TICK: begin
            if (busy_r) begin
              if (!bit_r[4]) begin
                for (int m = 0; m < MOTORS; m++) begin
                  pins_nxt[m] = (sub_r < 3'd2) ||
                                (sub_r < 3'd4 && word_r[m][4'd15 - bit_r[3:0]]);
                end
                if (sub_r == 3'd4) begin
                  sub_nxt = '0;
                  bit_nxt = bit_r + 1'b1;
                end else begin
                  sub_nxt = sub_r + 1'b1;
                end
              end else if (rcnt_r == RCNT_W'(RESET_SLOTS - 1)) begin
                // Last reset slot: close the frame, count down the repeats.
                fend_nxt = 1'b1;
                bit_nxt  = '0;
                sub_nxt  = '0;
                rcnt_nxt = '0;
                rep_nxt  = rep_dec;
                busy_nxt = (rep_dec != '0);
              end else begin
                rcnt_nxt = rcnt_r + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
    out_valid_nxt = pop || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < STORE_N; m++) begin
        thr_r[m]  <= '0;
        tel_r[m]  <= 1'b0;
        word_r[m] <= '0;
      end
      bit_r       <= '0;
      sub_r       <= '0;
      rcnt_r      <= '0;
      rep_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      thr_r       <= thr_nxt;
      tel_r       <= tel_nxt;
      word_r      <= word_nxt;
      bit_r       <= bit_nxt;
      sub_r       <= sub_nxt;
      rcnt_r      <= rcnt_nxt;
      rep_r       <= rep_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pins_r <= pins_nxt;
      fend_r <= fend_nxt;
      send_r <= busy_nxt;
      stat_r <= stat_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dshot600_four_channel_transmitter_unit.sv
// ----------------------------------------------------------------------------
// DShot600 four-channel transmitter
// Slot-level DShot600 packet generator for four motor outputs.
// ----------------------------------------------------------------------------
// Each request on in_ch gives exactly one result on out_ch, in order. Requests
// set a motor's throttle (clamped to the ceiling, then nonzero values raised to
// the floor), start a frame from the stored throttles, start a repeated command
// frame, advance one output slot, or stop all motors. A slot tick returns the
// four pin levels for that slot: 16 bits MSB first, five slots per bit (high,
// high, data, data, low), then RESET_SLOTS low slots; frame_end marks the last
// reset slot. While a frame is in progress every request other than a tick or
// an unknown action is refused with the busy status. The block takes one
// request per clock: in_ch.ready stays high as long as the two-entry operation
// queue between the front end and the execution stage has room, and with the
// result channel ready each request passes through the queue and then the
// result register. Throughput is set by the execution stage, which retires one
// operation per cycle whenever the result register is free or being drained.
// Write the limit registers over cfg_* only while idle.
`default_nettype none

module dshot600_four_channel_transmitter_unit
  import dsh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [VAL_W-1:0] cfg_data,
  dsh_in_if.sink                in_ch,
  dsh_out_if.source             out_ch
);

  op_t     front_op;   // classified request entering the queue
  op_t     back_op;    // head of the queue
  logic    push;
  logic    pop;
  q_ctrl_t qc;

  // Front end: hold the limits, accept, clamp and classify.
  dsh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (qc.full),
    .push      (push),
    .op        (front_op)
  );

  // Decouple request intake from execution.
  dsh_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .op_in  (front_op),
    .pop    (pop),
    .ctrl   (qc),
    .op_out (back_op)
  );

  // Back end: apply operations, advance slots, register results.
  dsh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (qc.empty),
    .op      (back_op),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: hdl/dsh_checker.sv
// ----------------------------------------------------------------------------
// DShot600 transmitter checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dshot600_four_channel_transmitter_unit_macros.svh"

module dsh_checker
  import dsh_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [PIN_W-1:0] out_pins,
  input wire logic             out_frame_end,
  input wire logic             out_sending,
  input wire logic [1:0]       out_status
);

  `DSH_ASSERT_ALWAYS(a_no_result_after_reset, !rst_n |=> !out_valid, "result valid after reset")
  `DSH_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `DSH_ASSERT(a_pins_while_sending, out_valid && out_pins != '0 |-> out_sending, "pins high while idle")
  `DSH_ASSERT(a_busy_means_sending, out_valid && (out_status == ST_BUSY) |-> out_sending && !out_frame_end && out_pins == '0, "busy refusal while idle")

endmodule

bind dshot600_four_channel_transmitter_unit dsh_checker u_dsh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_pins      (out_ch.pin_levels),
  .out_frame_end (out_ch.frame_end),
  .out_sending   (out_ch.sending),
  .out_status    (out_ch.status)
);

`default_nettype wire
